>>> design/distance_vector_route_table_unit_assert.svh
// assertion macros shared by the checker of the route table unit
// needs clk and rst_n in scope at the point of use
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_UNIT_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_UNIT_ASSERT_SVH

// condition that holds on every clock edge outside reset
`define DVRT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define DVRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DVRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dvrt_pkg.sv
// shared types and constants of the distance-vector route table unit
// no dependencies
`timescale 1ns / 1ps

package dvrt_pkg;

  localparam int DEF_TABLE_DEPTH     = 32;
  localparam int DEF_INFINITY_METRIC = 16;

  localparam int ID_W   = 8;
  localparam int DIST_W = 5;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;

  // operation codes, code 3 is unused
  typedef enum logic [OP_W-1:0] {
    OP_MERGE  = 2'd0,
    OP_ADD    = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_KEPT     = 3'd2,
    ST_UNREACH  = 3'd3,
    ST_SELF     = 3'd4,
    ST_FULL     = 3'd5,
    ST_HIT      = 3'd6,
    ST_MISS     = 3'd7
  } status_t;

  // one stored route
  typedef struct packed {
    logic [ID_W-1:0]   dest;
    logic [ID_W-1:0]   hop;
    logic [DIST_W-1:0] metric;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> design/dvrt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/distance_vector_route_table_unit.sv
// top level of the distance-vector route table: sequencer, scan compare, valid bits
// depends on dvrt_pkg and dvrt_ram
`timescale 1ns / 1ps
//
// channel | ports                                    | direction
// --------+------------------------------------------+----------
// in      | in_valid, in_ready, in_operation ...     | request word in
// out     | out_valid, out_ready, out_status, hop    | result word out
// cfg     | cfg_valid, cfg_ready, cfg_own_node_id    | own node id write
//
// every request word walks the whole table through one ram read port, one entry a
// cycle, with one shared compare unit; the drain, decide and resp states follow the scan and
// come before the result is registered; no new word is accepted before then.
// in_ready is high only while the sequencer is idle; a new word may be accepted
// while the previous result still waits on out_ready.
// a stalled output holds the final result register until it is taken.
// reset clears all valid bits at once; there is no clearing pass.

module distance_vector_route_table_unit
  import dvrt_pkg::*;
#(
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int INFINITY_METRIC = DEF_INFINITY_METRIC
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ID_W-1:0]   in_neighbor_id,
  input  logic [ID_W-1:0]   in_destination,
  input  logic [DIST_W-1:0] in_route_distance,
  input  logic [ID_W-1:0]   in_given_next_hop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [ID_W-1:0]   out_next_hop_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_own_node_id
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0]     LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [DIST_W:0]   INF_D1   = (DIST_W + 1)'(INFINITY_METRIC);
  localparam logic [DIST_W-1:0] INF_D    = DIST_W'(INFINITY_METRIC);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]     chk_idx_r, chk_idx_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     found_idx_r, found_idx_nxt;
  logic [DIST_W-1:0] found_dist_r, found_dist_nxt;
  logic [ID_W-1:0]   found_hop_r, found_hop_nxt;
  logic              free_ok_r, free_ok_nxt;
  logic [AW-1:0]     free_idx_r, free_idx_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ID_W-1:0]   nbr_r, nbr_nxt;
  logic [ID_W-1:0]   dest_r, dest_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [ID_W-1:0]   ghop_r, ghop_nxt;
  logic [ID_W-1:0]   own_id_r, own_id_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [ID_W-1:0]   res_hop_r, res_hop_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [ID_W-1:0]   out_hop_r, out_hop_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  logic               hit_c;
  logic               free_c;
  logic [DIST_W:0]    d1;

  // entry store: destination, next hop and distance per slot
  dvrt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_r),
    .rdata(ram_rdata)
  );

  // shared compare unit on the entry read last cycle
  assign rd_entry = entry_t'(ram_rdata);
  assign hit_c    = chk_vld_r && valid_r[chk_idx_r] && (rd_entry.dest == dest_r);
  assign free_c   = chk_vld_r && !valid_r[chk_idx_r];
  assign d1       = {1'b0, dist_r} + {{DIST_W{1'b0}}, 1'b1};

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = out_stat_r;
  assign out_next_hop_out = out_hop_r;

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    found_dist_nxt = found_dist_r;
    found_hop_nxt  = found_hop_r;
    free_ok_nxt    = free_ok_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    op_nxt         = op_r;
    nbr_nxt        = nbr_r;
    dest_nxt       = dest_r;
    dist_nxt       = dist_r;
    ghop_nxt       = ghop_r;
    own_id_nxt     = own_id_r;
    res_stat_nxt   = res_stat_r;
    res_hop_nxt    = res_hop_r;
    out_valid_nxt  = out_valid_r;
    out_stat_nxt   = out_stat_r;
    out_hop_nxt    = out_hop_r;
    ram_we         = 1'b0;
    ram_waddr      = found_idx_r;
    ram_wdata      = '0;

    // configuration write
    if (cfg_valid) begin
      own_id_nxt = cfg_own_node_id;
    end

    // result word taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // first matching entry and first free slot seen during the scan
    if (hit_c && !found_r) begin
      found_nxt      = 1'b1;
      found_idx_nxt  = chk_idx_r;
      found_dist_nxt = rd_entry.metric;
      found_hop_nxt  = rd_entry.hop;
    end
    if (free_c && !free_ok_r) begin
      free_ok_nxt  = 1'b1;
      free_idx_nxt = chk_idx_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_operation;
          nbr_nxt     = in_neighbor_id;
          dest_nxt    = in_destination;
          dist_nxt    = in_route_distance;
          ghop_nxt    = in_given_next_hop;
          cnt_nxt     = '0;
          chk_vld_nxt = 1'b0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = cnt_r;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        chk_vld_nxt = 1'b0;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        res_hop_nxt  = '0;
        res_stat_nxt = ST_MISS;
        unique case (op_r)
          OP_MERGE: begin
            if (d1 >= INF_D1) begin
              res_stat_nxt = ST_UNREACH;
            end else if (dest_r == own_id_r) begin
              res_stat_nxt = ST_SELF;
            end else if (found_r) begin
              if (d1 < {1'b0, found_dist_r}) begin
                ram_we       = 1'b1;
                ram_waddr    = found_idx_r;
                ram_wdata    = '{dest: dest_r, hop: nbr_r, metric: d1[DIST_W-1:0]};
                res_stat_nxt = ST_REPLACED;
              end else begin
                res_stat_nxt = ST_KEPT;
              end
            end else if (free_ok_r) begin
              ram_we                = 1'b1;
              ram_waddr             = free_idx_r;
              ram_wdata             = '{dest: dest_r, hop: nbr_r, metric: d1[DIST_W-1:0]};
              valid_nxt[free_idx_r] = 1'b1;
              res_stat_nxt          = ST_INSERTED;
            end else begin
              res_stat_nxt = ST_FULL;
            end
          end
          OP_ADD: begin
            if (found_r) begin
              res_stat_nxt = ST_KEPT;
            end else if (free_ok_r) begin
              ram_we                = 1'b1;
              ram_waddr             = free_idx_r;
              ram_wdata             = '{dest: dest_r, hop: ghop_r, metric: dist_r};
              valid_nxt[free_idx_r] = 1'b1;
              res_stat_nxt          = ST_INSERTED;
            end else begin
              res_stat_nxt = ST_FULL;
            end
          end
          OP_LOOKUP: begin
            if (found_r && (found_dist_r < INF_D)) begin
              res_stat_nxt = ST_HIT;
              res_hop_nxt  = found_hop_r;
            end
          end
          default: begin
            res_stat_nxt = ST_MISS;
          end
        endcase
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_hop_nxt   = res_hop_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      free_ok_r   <= 1'b0;
      valid_r     <= '0;
      own_id_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      found_r     <= found_nxt;
      free_ok_r   <= free_ok_nxt;
      valid_r     <= valid_nxt;
      own_id_r    <= own_id_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    chk_idx_r    <= chk_idx_nxt;
    found_idx_r  <= found_idx_nxt;
    found_dist_r <= found_dist_nxt;
    found_hop_r  <= found_hop_nxt;
    free_idx_r   <= free_idx_nxt;
    op_r         <= op_nxt;
    nbr_r        <= nbr_nxt;
    dest_r       <= dest_nxt;
    dist_r       <= dist_nxt;
    ghop_r       <= ghop_nxt;
    res_stat_r   <= res_stat_nxt;
    res_hop_r    <= res_hop_nxt;
    out_stat_r   <= out_stat_nxt;
    out_hop_r    <= out_hop_nxt;
  end

endmodule

>>> design/dvrt_checker.sv
// port-level checker of the route table unit and its bind
// depends on dvrt_pkg and distance_vector_route_table_unit_assert.svh
`timescale 1ns / 1ps
`include "distance_vector_route_table_unit_assert.svh"

module dvrt_checker
  import dvrt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [ID_W-1:0]   out_next_hop_out
);

  // a stalled result word holds
  `DVRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_next_hop_out), "result word changed while stalled")

  // next hop is zero unless the word is a hit
  `DVRT_ASSERT_ALWAYS(a_hop_zero, !out_valid || (out_status == ST_HIT) || (out_next_hop_out == '0), "next hop set on a non-hit result")

  // the table scan keeps the block busy after an accept
  `DVRT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after an accepted word")

  // a new result appears only as the sequencer returns to idle
  `DVRT_ASSERT_IMPL(a_idle_on_result, $rose(out_valid), in_ready, "result raised while sequencer busy")

endmodule

bind distance_vector_route_table_unit dvrt_checker u_dvrt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_next_hop_out(out_next_hop_out)
);
